### design/dfs_pkg.sv
`timescale 1ns / 1ps
package dfs_pkg;
    localparam int MAX_VERTICES_DEF   = 64;
    localparam int MAX_OUT_DEGREE_DEF = 8;
    localparam int VERTEX_W           = 6;
    localparam int COUNT_W            = 7;

    // input actions
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLR   = 10'b0000000010,
        S_ROOT  = 10'b0000000100,
        S_TOPRD = 10'b0000001000,
        S_TOP   = 10'b0000010000,
        S_ADJ   = 10'b0000100000,
        S_VIS   = 10'b0001000000,
        S_EMITR = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_ADD   = 10'b1000000000
    } state_t;
endpackage

### design/dfs_graph_mem.sv
`timescale 1ns / 1ps
module dfs_graph_mem #(
    parameter int MAX_VERTICES   = dfs_pkg::MAX_VERTICES_DEF,
    parameter int MAX_OUT_DEGREE = dfs_pkg::MAX_OUT_DEGREE_DEF,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int EW = (MAX_OUT_DEGREE > 1) ? $clog2(MAX_OUT_DEGREE) : 1
)
(
    input  logic                              clk,
    input  logic                              adj_we,
    input  logic [VW-1:0]                     adj_wv,
    input  logic [EW-1:0]                     adj_we_idx,
    input  logic [dfs_pkg::VERTEX_W-1:0]      adj_wdata,
    input  logic [VW-1:0]                     adj_rv,
    input  logic [EW-1:0]                     adj_re_idx,
    output logic [dfs_pkg::VERTEX_W-1:0]      adj_rdata
);
    localparam int AW = $clog2(MAX_VERTICES * MAX_OUT_DEGREE);

    logic [dfs_pkg::VERTEX_W-1:0] adj_mem [MAX_VERTICES*MAX_OUT_DEGREE];

    // adjacency slot memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[AW'(adj_wv*MAX_OUT_DEGREE + adj_we_idx)] <= adj_wdata;
        end
        adj_rdata <= adj_mem[AW'(adj_rv*MAX_OUT_DEGREE + adj_re_idx)];
    end
endmodule

### design/dfs_topological_sort.sv
`timescale 1ns / 1ps
// dfs_topological_sort: directed graph store with depth-first topological sort
// Commands are taken when start is high and busy is low. action 0 adds an edge
// (one result on the cycle after acceptance when a vertex is out of range,
// after the S_ADD state otherwise), 2 clears all edges (one result after a
// sweep of all MAX_VERTICES degree entries), 1 runs the sort and emits
// vertex_count results, each read in S_EMITR and sent in S_EMIT, top of the
// finish stack first, last marking the final one. A run keeps busy high;
// its pace is set by the registered reads of the stack, degree, adjacency
// and finish memories. One command at a time.
// Results appear for one cycle with result_valid; the receiver cannot stall.
// The config channel writes vertex_count (0 acts as 1, above MAX_VERTICES
// clips); write only while idle. Reset clears the degree table by a sweep of
// all MAX_VERTICES entries, with busy high; vertex_count resets to 64.
module dfs_topological_sort #(
    parameter int MAX_VERTICES   = dfs_pkg::MAX_VERTICES_DEF,
    parameter int MAX_OUT_DEGREE = dfs_pkg::MAX_OUT_DEGREE_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       action,
    input  logic [dfs_pkg::VERTEX_W-1:0]     from_vertex,
    input  logic [dfs_pkg::VERTEX_W-1:0]     to_vertex,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dfs_pkg::COUNT_W-1:0]      cfg_data,
    output logic                             result_valid,
    output logic [dfs_pkg::VERTEX_W-1:0]     vertex,
    output logic [1:0]                       status,
    output logic                             last
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = (MAX_OUT_DEGREE > 1) ? $clog2(MAX_OUT_DEGREE) : 1;
    localparam int DW = $clog2(MAX_OUT_DEGREE + 1);
    localparam int CW = VW + 1;
    localparam logic [CW-1:0] NMAX = CW'(MAX_VERTICES);
    localparam logic [DW-1:0] DMAX = DW'(MAX_OUT_DEGREE);

    dfs_pkg::state_t state_reg, state_next;
    logic [dfs_pkg::COUNT_W-1:0] vcount_reg;
    logic [CW-1:0] n_act;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic [CW-1:0] fin_reg, fin_next;
    logic [VW-1:0] from_reg, from_next, to_reg, to_next;
    logic [VW-1:0] cur_v_reg, cur_v_next;
    logic [DW-1:0] cur_e_reg, cur_e_next;
    logic [VW-1:0] tgt_reg, tgt_next;
    logic          after_reg, after_next;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;

    logic                    rv_valid_reg, rv_valid_next;
    logic [dfs_pkg::VERTEX_W-1:0] rv_vertex_reg, rv_vertex_next;
    logic [1:0]              rv_status_reg, rv_status_next;
    logic                    rv_last_reg, rv_last_next;

    // degree memory
    logic [DW-1:0] deg_mem [MAX_VERTICES];
    logic [DW-1:0] deg_rdata;
    logic [VW-1:0] deg_ra, deg_wa;
    logic          deg_we;
    logic [DW-1:0] deg_wd;
    // search stack memory: vertex and next edge index
    logic [VW+DW-1:0] stk_mem [MAX_VERTICES];
    logic [VW+DW-1:0] stk_rdata, stk_wd;
    logic [VW-1:0]    stk_ra, stk_wa;
    logic             stk_we;
    // finish stack memory
    logic [VW-1:0] fin_mem [MAX_VERTICES];
    logic [VW-1:0] fin_rdata, fin_ra, fin_wa, fin_wd;
    logic          fin_we;
    // adjacency port
    logic          adj_we;
    logic [EW-1:0] adj_widx, adj_ridx;
    logic [VW-1:0] adj_rv;
    logic [dfs_pkg::VERTEX_W-1:0] adj_rdata;

    always_ff @(posedge clk)
    begin
        if (deg_we) deg_mem[deg_wa] <= deg_wd;
        deg_rdata <= deg_mem[deg_ra];
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_rdata <= stk_mem[stk_ra];
        if (fin_we) fin_mem[fin_wa] <= fin_wd;
        fin_rdata <= fin_mem[fin_ra];
    end

    dfs_graph_mem #(
        .MAX_VERTICES   (MAX_VERTICES),
        .MAX_OUT_DEGREE (MAX_OUT_DEGREE)
    ) u_graph (
        .clk        (clk),
        .adj_we     (adj_we),
        .adj_wv     (from_reg),
        .adj_we_idx (adj_widx),
        .adj_wdata  (dfs_pkg::VERTEX_W'(to_reg)),
        .adj_rv     (adj_rv),
        .adj_re_idx (adj_ridx),
        .adj_rdata  (adj_rdata)
    );

    // effective vertex count
    always_comb
    begin
        if (vcount_reg == '0)
            n_act = CW'(1);
        else if (vcount_reg > dfs_pkg::COUNT_W'(MAX_VERTICES))
            n_act = NMAX;
        else
            n_act = CW'(vcount_reg);
    end

    assign busy      = (state_reg != dfs_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = rv_valid_reg;
    assign vertex = rv_vertex_reg;
    assign status = rv_status_reg;
    assign last   = rv_last_reg;

    // sequencer
    always_comb
    begin
        logic [VW+DW-1:0] top_entry;
        state_next = state_reg;
        scan_next = scan_reg; depth_next = depth_reg; fin_next = fin_reg;
        from_next = from_reg; to_next = to_reg;
        cur_v_next = cur_v_reg; cur_e_next = cur_e_reg; tgt_next = tgt_reg;
        after_next = after_reg; vis_next = vis_reg;
        rv_valid_next = 1'b0; rv_vertex_next = '0; rv_status_next = dfs_pkg::ST_OK;
        rv_last_next = 1'b1;
        deg_ra = from_reg; deg_wa = scan_reg[VW-1:0]; deg_we = 1'b0; deg_wd = '0;
        stk_ra = depth_reg[VW-1:0] - VW'(1); stk_wa = depth_reg[VW-1:0];
        stk_we = 1'b0; stk_wd = '0;
        fin_ra = fin_reg[VW-1:0] - VW'(1); fin_wa = fin_reg[VW-1:0];
        fin_we = 1'b0; fin_wd = cur_v_reg;
        adj_we = 1'b0; adj_widx = '0;
        adj_rv = cur_v_reg; adj_ridx = cur_e_reg[EW-1:0];
        top_entry = stk_rdata;
        case (state_reg)
            dfs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    from_next = VW'(from_vertex);
                    to_next   = VW'(to_vertex);
                    case (action)
                        dfs_pkg::ACT_ADD:
                        begin
                            if (dfs_pkg::COUNT_W'(from_vertex) >= dfs_pkg::COUNT_W'(n_act)
                                || dfs_pkg::COUNT_W'(to_vertex) >= dfs_pkg::COUNT_W'(n_act))
                            begin
                                rv_valid_next = 1'b1;
                                rv_status_next = dfs_pkg::ST_RANGE;
                            end
                            else
                            begin
                                deg_ra = VW'(from_vertex);
                                state_next = dfs_pkg::S_ADD;
                            end
                        end
                        dfs_pkg::ACT_RUN:
                        begin
                            vis_next = '0; scan_next = '0; fin_next = '0;
                            depth_next = '0; state_next = dfs_pkg::S_ROOT;
                        end
                        dfs_pkg::ACT_CLEAR:
                        begin
                            scan_next = '0; after_next = 1'b1;
                            state_next = dfs_pkg::S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            dfs_pkg::S_ADD:
            begin
                // degree read back, store edge and bump unless the degree is full
                if (deg_rdata >= DMAX)
                    rv_status_next = dfs_pkg::ST_FULL;
                else
                begin
                    adj_we = 1'b1; adj_widx = deg_rdata[EW-1:0];
                    deg_we = 1'b1; deg_wa = from_reg; deg_wd = deg_rdata + DW'(1);
                end
                rv_valid_next = 1'b1;
                state_next = dfs_pkg::S_IDLE;
            end
            dfs_pkg::S_CLR:
            begin
                // sweep degree table to zero
                deg_we = 1'b1;
                scan_next = scan_reg + CW'(1);
                if (scan_reg == NMAX - CW'(1))
                begin
                    scan_next = '0;
                    state_next = dfs_pkg::S_IDLE;
                    rv_valid_next = after_reg;
                end
            end
            dfs_pkg::S_ROOT:
            begin
                // next unvisited root or start emitting
                if (scan_reg >= n_act)
                    state_next = dfs_pkg::S_EMITR;
                else if (vis_reg[scan_reg[VW-1:0]])
                    scan_next = scan_reg + CW'(1);
                else
                begin
                    vis_next[scan_reg[VW-1:0]] = 1'b1;
                    stk_we = 1'b1; stk_wa = '0;
                    stk_wd = {scan_reg[VW-1:0], DW'(0)};
                    depth_next = CW'(1);
                    state_next = dfs_pkg::S_TOPRD;
                end
            end
            dfs_pkg::S_TOPRD:
            begin
                // stack top read issued by default address
                state_next = dfs_pkg::S_TOP;
            end
            dfs_pkg::S_TOP:
            begin
                cur_v_next = top_entry[VW+DW-1:DW];
                cur_e_next = top_entry[DW-1:0];
                deg_ra = top_entry[VW+DW-1:DW];
                adj_rv = top_entry[VW+DW-1:DW];
                adj_ridx = top_entry[EW-1:0];
                state_next = dfs_pkg::S_ADJ;
            end
            dfs_pkg::S_ADJ:
            begin
                if (cur_e_reg < deg_rdata)
                begin
                    // advance edge index of the top entry
                    stk_we = 1'b1; stk_wa = depth_reg[VW-1:0] - VW'(1);
                    stk_wd = {cur_v_reg, cur_e_reg + DW'(1)};
                    tgt_next = adj_rdata[VW-1:0];
                    if (CW'(adj_rdata) < n_act)
                        state_next = dfs_pkg::S_VIS;
                    else
                        state_next = dfs_pkg::S_TOPRD;
                end
                else
                begin
                    // vertex finished
                    if (fin_reg < NMAX)
                    begin
                        fin_we = 1'b1;
                        fin_next = fin_reg + CW'(1);
                    end
                    depth_next = depth_reg - CW'(1);
                    if (depth_reg == CW'(1))
                    begin
                        scan_next = scan_reg + CW'(1);
                        state_next = dfs_pkg::S_ROOT;
                    end
                    else
                        state_next = dfs_pkg::S_TOPRD;
                end
            end
            dfs_pkg::S_VIS:
            begin
                // push target if unvisited
                if (!vis_reg[tgt_reg] && depth_reg < NMAX)
                begin
                    vis_next[tgt_reg] = 1'b1;
                    stk_we = 1'b1;
                    stk_wd = {tgt_reg, DW'(0)};
                    depth_next = depth_reg + CW'(1);
                end
                state_next = dfs_pkg::S_TOPRD;
            end
            dfs_pkg::S_EMITR:
            begin
                state_next = dfs_pkg::S_EMIT;
            end
            dfs_pkg::S_EMIT:
            begin
                rv_valid_next = 1'b1;
                rv_vertex_next = dfs_pkg::VERTEX_W'(fin_rdata);
                rv_last_next = (fin_reg == CW'(1));
                fin_next = fin_reg - CW'(1);
                scan_next = '0;
                if (fin_reg == CW'(1))
                    state_next = dfs_pkg::S_IDLE;
                else
                    state_next = dfs_pkg::S_EMITR;
            end
            default:
            begin
                state_next = dfs_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfs_pkg::S_CLR;
            vcount_reg <= dfs_pkg::COUNT_W'(64);
            scan_reg <= '0; depth_reg <= '0; fin_reg <= '0;
            after_reg <= 1'b0; vis_reg <= '0;
            rv_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                vcount_reg <= cfg_data;
            scan_reg <= scan_next; depth_reg <= depth_next; fin_reg <= fin_next;
            after_reg <= after_next; vis_reg <= vis_next;
            rv_valid_reg <= rv_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        from_reg <= from_next; to_reg <= to_next;
        cur_v_reg <= cur_v_next; cur_e_reg <= cur_e_next; tgt_reg <= tgt_next;
        rv_vertex_reg <= rv_vertex_next; rv_status_reg <= rv_status_next;
        rv_last_reg <= rv_last_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_depth: assert property (@(posedge clk) disable iff (!rst_n) depth_reg <= NMAX)
        else $error("stack overflow");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n) fin_reg <= NMAX)
        else $error("finish overflow");
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfs_pkg::S_EMIT) |-> fin_reg != '0)
        else $error("emit from empty finish stack");
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    localparam int NV = dfs_pkg::MAX_VERTICES_DEF;
    localparam int ND = dfs_pkg::MAX_OUT_DEGREE_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [dfs_pkg::VERTEX_W-1:0] vtx;
        logic [1:0]                   st;
        logic                         lst;
    } order_item_t;

    // directed row: optional vertex_count write, else one command
    typedef struct {
        bit                           is_cfg;
        logic [dfs_pkg::COUNT_W-1:0]  cfg_val;
        logic [1:0]                   act;
        logic [dfs_pkg::VERTEX_W-1:0] src;
        logic [dfs_pkg::VERTEX_W-1:0] dst;
        bit                           typed;
        logic [1:0]                   typed_st;
    } cmd_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   action;
    logic [dfs_pkg::VERTEX_W-1:0] from_vertex;
    logic [dfs_pkg::VERTEX_W-1:0] to_vertex;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [dfs_pkg::COUNT_W-1:0]  cfg_data;
    logic                         result_valid;
    logic [dfs_pkg::VERTEX_W-1:0] vertex;
    logic [1:0]                   status;
    logic                         last;

    // graph mirror
    logic [dfs_pkg::VERTEX_W-1:0] adj_tgt [NV][ND];
    int                           deg [NV];
    int                           n_used;
    bit                           vis [NV];
    logic [dfs_pkg::VERTEX_W-1:0] stk_v [NV];
    int                           stk_e [NV];
    logic [dfs_pkg::VERTEX_W-1:0] fin_stk [NV];
    int                           fin_cnt;

    order_item_t order_q[$];
    order_item_t step_q[$];
    int          errors;
    int          stall_cnt;
    int          items_sent;
    int          results_seen;
    int          runs_sent;
    bit          idle_on;

    cmd_row_t    dir_rows[$];

    dfs_topological_sort u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .from_vertex  (from_vertex),
        .to_vertex    (to_vertex),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .vertex       (vertex),
        .status       (status),
        .last         (last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // depth-first search from one root, finish order into fin_stk
    task automatic search_root(input int root);
        int depth;
        int v;
        int e;
        int t;
        vis[root] = 1'b1;
        stk_v[0] = dfs_pkg::VERTEX_W'(root);
        stk_e[0] = 0;
        depth = 1;
        while (depth > 0)
        begin
            v = int'(stk_v[depth-1]);
            e = stk_e[depth-1];
            if (e < deg[v])
            begin
                t = int'(adj_tgt[v][e]);
                stk_e[depth-1] = e + 1;
                if (t < n_used && !vis[t] && depth < NV)
                begin
                    vis[t] = 1'b1;
                    stk_v[depth] = dfs_pkg::VERTEX_W'(t);
                    stk_e[depth] = 0;
                    depth++;
                end
            end
            else
            begin
                if (fin_cnt < NV)
                begin
                    fin_stk[fin_cnt] = dfs_pkg::VERTEX_W'(v);
                    fin_cnt++;
                end
                depth--;
            end
        end
    endtask

    // expected results of one command into step_q
    task automatic predict_order(input logic [1:0] a, input int src, input int dst);
        order_item_t r;
        step_q.delete();
        r = '0;
        r.lst = 1'b1;
        case (a)
            dfs_pkg::ACT_ADD:
            begin
                if (src >= n_used || dst >= n_used)
                    r.st = dfs_pkg::ST_RANGE;
                else if (deg[src] >= ND)
                    r.st = dfs_pkg::ST_FULL;
                else
                begin
                    adj_tgt[src][deg[src]] = dfs_pkg::VERTEX_W'(dst);
                    deg[src]++;
                    r.st = dfs_pkg::ST_OK;
                end
                step_q.insert(step_q.size(), r);
            end
            dfs_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < NV; i++)
                    deg[i] = 0;
                r.st = dfs_pkg::ST_OK;
                step_q.insert(step_q.size(), r);
            end
            dfs_pkg::ACT_RUN:
            begin
                for (int i = 0; i < NV; i++)
                    vis[i] = 1'b0;
                fin_cnt = 0;
                for (int i = 0; i < n_used; i++)
                    if (!vis[i])
                        search_root(i);
                while (fin_cnt > 0)
                begin
                    fin_cnt--;
                    r.vtx = fin_stk[fin_cnt];
                    r.st = dfs_pkg::ST_OK;
                    r.lst = (fin_cnt == 0);
                    step_q.insert(step_q.size(), r);
                end
            end
            default: ;
        endcase
    endtask

    // one command transaction, optional typed status for single results
    task automatic send_cmd(input logic [1:0] a, input int src, input int dst,
                            input bit typed, input logic [1:0] typed_st);
        order_item_t r;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 17)
        begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        start = 1'b1;
        action = a;
        from_vertex = dfs_pkg::VERTEX_W'(src);
        to_vertex = dfs_pkg::VERTEX_W'(dst);
        do
            @(posedge clk);
        while (busy);
        predict_order(a, src, dst);
        foreach (step_q[i])
        begin
            r = step_q[i];
            if (typed)
                r.st = typed_st;
            order_q.insert(order_q.size(), r);
        end
        items_sent++;
        if (a == dfs_pkg::ACT_RUN)
            runs_sent++;
    endtask

    // vertex_count write while the block is quiet
    task automatic write_count(input logic [dfs_pkg::COUNT_W-1:0] val);
        @(negedge clk);
        start = 1'b0;
        wait (order_q.size() == 0);
        // an ignored command may still be in flight
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (val == 0)
            n_used = 1;
        else if (val > NV)
            n_used = NV;
        else
            n_used = int'(val);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data = dfs_pkg::COUNT_W'($urandom);
    endtask

    // result checker
    always @(posedge clk)
    begin
        order_item_t e;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (order_q.size() == 0)
                report($sformatf("unexpected result vertex=%0d status=%0d last=%0d",
                                 vertex, status, last));
            else
            begin
                e = order_q.pop_front();
                if (vertex !== e.vtx)
                    report($sformatf("vertex %0d, want %0d", vertex, e.vtx));
                if (status !== e.st)
                    report($sformatf("status %0d, want %0d", status, e.st));
                if (last !== e.lst)
                    report($sformatf("last %0d, want %0d", last, e.lst));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic add_row(input logic [1:0] a, input int src, input int dst,
                           input bit typed, input logic [1:0] st);
        cmd_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_val = '0;
        row.act = a;
        row.src = dfs_pkg::VERTEX_W'(src);
        row.dst = dfs_pkg::VERTEX_W'(dst);
        row.typed = typed;
        row.typed_st = st;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic cfg_row(input logic [dfs_pkg::COUNT_W-1:0] val);
        cmd_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_val = val;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    initial
    begin
        logic [dfs_pkg::COUNT_W-1:0] counts [10] = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd8,
                                                    7'd64, 7'd17, 7'd33, 7'd100, 7'd64};
        int pick;
        int src;
        int dst;
        logic [1:0] a;

        errors = 0;
        stall_cnt = 0;
        items_sent = 0;
        results_seen = 0;
        runs_sent = 0;
        idle_on = 1'b1;
        n_used = NV;
        for (int i = 0; i < NV; i++)
            deg[i] = 0;
        rst_n = 1'b0;
        start = 1'b0;
        action = dfs_pkg::ACT_ADD;
        from_vertex = '0;
        to_vertex = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty run, self loop, cycle, degree full, range, stale edges
        add_row(dfs_pkg::ACT_RUN, 0, 0, 0, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_ADD, 0, 1, 1, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_ADD, 63, 63, 1, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_ADD, 1, 2, 1, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_ADD, 2, 0, 1, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_ADD, 0, 63, 1, dfs_pkg::ST_OK);
        for (int i = 3; i < 9; i++)
            add_row(dfs_pkg::ACT_ADD, 0, i, 1, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_ADD, 0, 42, 1, dfs_pkg::ST_FULL);
        add_row(ACT_NONE, 21, 42, 0, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_RUN, 0, 0, 0, dfs_pkg::ST_OK);
        cfg_row(7'd4);
        add_row(dfs_pkg::ACT_ADD, 5, 0, 1, dfs_pkg::ST_RANGE);
        add_row(dfs_pkg::ACT_ADD, 0, 4, 1, dfs_pkg::ST_RANGE);
        add_row(dfs_pkg::ACT_ADD, 3, 3, 1, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_RUN, 0, 0, 0, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_CLEAR, 0, 0, 1, dfs_pkg::ST_OK);
        add_row(dfs_pkg::ACT_RUN, 0, 0, 0, dfs_pkg::ST_OK);

        foreach (dir_rows[i])
            if (dir_rows[i].is_cfg)
                write_count(dir_rows[i].cfg_val);
            else
                send_cmd(dir_rows[i].act, dir_rows[i].src, dir_rows[i].dst,
                         dir_rows[i].typed, dir_rows[i].typed_st);

        // random phases, each under its own vertex_count
        for (int ph = 0; ph < 10; ph++)
        begin
            write_count(counts[ph]);
            idle_on = (ph != 5);
            for (int k = 0; k < 42; k++)
            begin
                pick = $urandom_range(99);
                src = $urandom_range(n_used - 1);
                dst = $urandom_range(n_used - 1);
                if (pick < 8)
                    a = dfs_pkg::ACT_RUN;
                else if (pick < 12)
                    a = dfs_pkg::ACT_CLEAR;
                else if (pick < 14)
                begin
                    a = ACT_NONE;
                    src = $urandom_range(63);
                    dst = $urandom_range(63);
                end
                else
                begin
                    a = dfs_pkg::ACT_ADD;
                    // occasional out-of-range or fully random vertices
                    if ($urandom_range(9) == 0)
                    begin
                        src = $urandom_range(63);
                        dst = $urandom_range(63);
                    end
                end
                send_cmd(a, src, dst, 0, dfs_pkg::ST_OK);
            end
            if ((ph % 3) == 2)
                send_cmd(dfs_pkg::ACT_RUN, 0, 0, 0, dfs_pkg::ST_OK);
        end

        @(negedge clk);
        start = 1'b0;
        wait (order_q.size() == 0);
        repeat (100) @(posedge clk);
        $display("tb_top: %0d commands (%0d sorts), %0d results checked", items_sent,
                 runs_sent, results_seen);
        $display("tb_top: vertex counts 0..127 incl. extremes, degree-full and range drops");
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
